// ===== sv/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad combination lock
// Event codes, mode encoding, reset code and the tries-left helper.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  localparam int KEY_W    = 8;
  localparam int TRIES_W  = 4;
  localparam int KEYS_W   = 3;
  localparam int CODE_LENGTH_DEF = 4;
  localparam logic [TRIES_W-1:0] MAX_TRIES_RST = 4'd3;
  localparam logic [TRIES_W-1:0] FAIL_SAT      = 4'd15;

  localparam logic [KEY_W-1:0] KEY_OPEN   = 8'd1;
  localparam logic [KEY_W-1:0] KEY_CHANGE = 8'd2;

  // Power-up code; entries past the fourth are zero.
  localparam logic [KEY_W-1:0] RESET_CODE [16] = '{
    8'd1, 8'd9, 8'd1, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef enum logic [3:0] {
    EV_KEY      = 4'd0,
    EV_OPEN     = 4'd1,
    EV_CHANGE   = 4'd2,
    EV_INVALID  = 4'd3,
    EV_WRONG    = 4'd4,
    EV_UNLOCKED = 4'd5,
    EV_ALARM    = 4'd6,
    EV_NEW_CODE = 4'd7,
    EV_UPDATED  = 4'd8
  } ev_e;

  typedef enum logic [3:0] {
    MODE_MENU   = 4'b0001,
    MODE_OPEN   = 4'b0010,
    MODE_CHANGE = 4'b0100,
    MODE_NEW    = 4'b1000
  } mode_e;

  typedef struct packed {
    logic wr_en;   // store the key into the entry buffer
    logic commit;  // copy buffer plus key into the stored code
  } entry_ctl_t;

  typedef struct packed {
    ev_e                ev;
    logic [TRIES_W-1:0] tries;
    logic [KEYS_W-1:0]  keys;
  } res_t;

  function automatic logic [TRIES_W-1:0] tries_rem(logic [TRIES_W-1:0] fails,
                                                    logic [TRIES_W-1:0] max_tries);
    tries_rem = (fails >= max_tries) ? '0 : max_tries - fails;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kcl_entry.sv =====
// ----------------------------------------------------------------------------
// kcl_entry: entry buffer, stored code and parallel compare
// Holds the keys of the running entry and the code; the last key is
// compared and committed straight from the request.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_entry #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire kcl_pkg::entry_ctl_t    ctl_i,
  input  wire [((CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1)-1:0] wr_idx_i,
  input  wire [kcl_pkg::KEY_W-1:0]    key_i,
  output logic                        match_o
);
  import kcl_pkg::*;

  logic [KEY_W-1:0] buf_q    [CODE_LENGTH];
  logic [KEY_W-1:0] stored_q [CODE_LENGTH];

  // Entry buffer: payload only, every slot is written before it is read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      buf_q[wr_idx_i] <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_q[i] <= RESET_CODE[i];
      end
    end else if (ctl_i.commit) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_q[i] <= (i == CODE_LENGTH - 1) ? key_i : buf_q[i];
      end
    end
  end

  always_comb begin
    match_o = (key_i == stored_q[CODE_LENGTH-1]);
    for (int i = 0; i < CODE_LENGTH - 1; i++) begin
      if (buf_q[i] != stored_q[i]) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/kcl_fsm.sv =====
// ----------------------------------------------------------------------------
// kcl_fsm: menu and attempt sequencer
// Tracks mode, key count and failures; decodes one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_fsm #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          fire_i,
  input  wire [kcl_pkg::KEY_W-1:0]     key_i,
  input  wire [kcl_pkg::TRIES_W-1:0]   max_tries_i,
  input  wire                          match_i,
  output kcl_pkg::entry_ctl_t          ctl_o,
  output logic [((CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1)-1:0] wr_idx_o,
  output kcl_pkg::res_t                res_o
);
  import kcl_pkg::*;

  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LENGTH - 1);

  mode_e              mode_q, mode_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TRIES_W-1:0] fail_q, fail_d;
  logic [CNT_W-1:0]   cnt_inc;
  logic [TRIES_W-1:0] fail_inc;
  entry_ctl_t         ctl;
  res_t               res;

  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign fail_inc = (fail_q == FAIL_SAT) ? FAIL_SAT : fail_q + TRIES_W'(1);
  assign wr_idx_o = cnt_q[IDX_W-1:0];

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    fail_d     = fail_q;
    ctl        = '0;
    res.ev     = EV_KEY;
    res.tries  = '0;
    res.keys   = '0;
    case (mode_q)
      MODE_MENU: begin
        if (key_i == KEY_OPEN || key_i == KEY_CHANGE) begin
          mode_d    = (key_i == KEY_OPEN) ? MODE_OPEN : MODE_CHANGE;
          res.ev    = (key_i == KEY_OPEN) ? EV_OPEN : EV_CHANGE;
          cnt_d     = '0;
          fail_d    = '0;
          res.tries = max_tries_i;
        end else begin
          res.ev = EV_INVALID;
        end
      end
      MODE_OPEN, MODE_CHANGE, MODE_NEW: begin
        ctl.wr_en = 1'b1;
        if (cnt_q != CNT_LAST) begin
          cnt_d     = cnt_inc;
          res.ev    = EV_KEY;
          res.keys  = KEYS_W'(cnt_inc);
          res.tries = (mode_q == MODE_NEW) ? '0 : tries_rem(fail_q, max_tries_i);
        end else if (mode_q == MODE_NEW) begin
          ctl.commit = 1'b1;
          res.ev     = EV_UPDATED;
          mode_d     = MODE_MENU;
          cnt_d      = '0;
        end else if (match_i) begin
          res.tries = tries_rem(fail_q, max_tries_i);
          cnt_d     = '0;
          if (mode_q == MODE_OPEN) begin
            res.ev = EV_UNLOCKED;
            mode_d = MODE_MENU;
          end else begin
            res.ev = EV_NEW_CODE;
            mode_d = MODE_NEW;
          end
        end else begin
          fail_d = fail_inc;
          cnt_d  = '0;
          if (fail_inc >= max_tries_i) begin
            res.ev = EV_ALARM;
            mode_d = MODE_MENU;
          end else begin
            res.ev    = EV_WRONG;
            res.tries = max_tries_i - fail_inc;
          end
        end
      end
      default: begin
        mode_d = MODE_MENU;
        cnt_d  = '0;
      end
    endcase
  end

  // Only act on a request that moves into the result register.
  assign ctl_o = fire_i ? ctl : '0;
  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MENU;
      cnt_q  <= '0;
      fail_q <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      fail_q <= fail_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/keypad_combination_lock.sv =====
// ----------------------------------------------------------------------------
// keypad_combination_lock: keypad-driven code lock
// One key per request, one result per request; open and change attempts
// against a stored code with a failure limit and alarm.
// ----------------------------------------------------------------------------
// Usage: each accepted key yields exactly one result; the key is loaded into the
// input register and its result into the result register once that register
// is free, and a new key can be taken every cycle while the result side is not
// stalled, so the sustained rate is one key per clock. The key is decoded and
// compared against all CODE_LENGTH stored keys in parallel in the single
// stage between the two registers. In the menu, key 1 starts an open attempt
// and key 2 a change attempt; other keys report as invalid. After power-up
// the code is 1,9,1,7 and max_tries is 3. Write max_tries only while no
// request is outstanding; the write port is always ready.
`default_nettype none

module keypad_combination_lock #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // key requests
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [kcl_pkg::KEY_W-1:0]     key_code_i,
  // results
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [3:0]                   event_res_o,
  output logic [kcl_pkg::TRIES_W-1:0]  tries_left_o,
  output logic [kcl_pkg::KEYS_W-1:0]   keys_entered_o,
  // max_tries write port
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [kcl_pkg::TRIES_W-1:0]   cfg_max_tries_i
);
  import kcl_pkg::*;

  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  logic               in_valid_q;
  logic [KEY_W-1:0]   key_q;
  logic               out_valid_q;
  res_t               res_q;
  logic [TRIES_W-1:0] max_tries_q;

  logic               advance;   // result register can take a new result
  logic               fire;      // held key is processed this cycle
  logic               in_take;
  logic               match;
  entry_ctl_t         entry_ctl;
  logic [IDX_W-1:0]   wr_idx;
  res_t               res;

  // Result register frees up when empty or when its result is taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  // Hold off only while the input register is full and cannot drain.
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q <= MAX_TRIES_RST;
    end else if (cfg_valid_i) begin
      max_tries_q <= cfg_max_tries_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_q <= key_code_i;
    end
  end

  kcl_entry #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_entry (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (entry_ctl),
    .wr_idx_i (wr_idx),
    .key_i    (key_q),
    .match_o  (match)
  );

  kcl_fsm #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .key_i       (key_q),
    .max_tries_i (max_tries_q),
    .match_i     (match),
    .ctl_o       (entry_ctl),
    .wr_idx_o    (wr_idx),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = res_q.ev;
  assign tries_left_o   = res_q.tries;
  assign keys_entered_o = res_q.keys;

  // A processed key always lands in the result register.
  a_fire_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed key produced no result");

  // Key counts only go with a stored-key event.
  a_keys_only_on_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.keys != '0) |-> (res_q.ev == EV_KEY))
    else $error("key count on a non-key event");

  // Terminal menu outcomes report no tries.
  a_no_tries_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.ev == EV_ALARM || res_q.ev == EV_INVALID ||
                     res_q.ev == EV_UPDATED)) |-> (res_q.tries == '0))
    else $error("tries reported on a final outcome");

  // Tries left never exceeds the configured limit.
  a_tries_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.tries <= max_tries_q))
    else $error("tries left above max_tries");

endmodule

`default_nettype wire
